>>> src/rnt_pkg.sv
// shared types and constants of the rejection notice table
package rnt_pkg;

	localparam int ID_W       = 64;
	localparam int NODE_W     = 16;
	localparam int STATUS_W   = 8;
	localparam int STEP_W     = 32;
	localparam int ENTRIES_W  = 5;
	localparam int INTERVAL_W = 16;
	localparam int CFG_DATA_W = 16;

	typedef logic [ID_W-1:0]       msg_id_t;
	typedef logic [NODE_W-1:0]     node_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [STEP_W-1:0]     step_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic                  op_t;
	typedef logic                  reg_index_t;

	localparam op_t OP_INSERT = 1'b0;
	localparam op_t OP_DRAIN  = 1'b1;

	localparam reg_index_t REG_ENTRIES_IN_USE    = 1'b0;
	localparam reg_index_t REG_MIN_SEND_INTERVAL = 1'b1;

	typedef enum logic [2:0] {
		RES_INSERTED = 3'd0,
		RES_DISABLED = 3'd1,
		RES_NOTHING  = 3'd2,
		RES_SENT     = 3'd3,
		RES_REFUSED  = 3'd4
	} result_kind_t;

endpackage

>>> src/rnt_if.sv
// request, response and configuration channel interfaces
interface rnt_req_if;
	import rnt_pkg::*;
	logic    valid;
	logic    ready;
	op_t     op;
	msg_id_t msg_id;
	node_t   target_node;
	status_t reject_status;
	step_t   step_now;
	logic    link_accepts;

	modport source (
		output valid, op, msg_id, target_node, reject_status, step_now, link_accepts,
		input ready
	);
	modport sink (
		input valid, op, msg_id, target_node, reject_status, step_now, link_accepts,
		output ready
	);
endinterface

interface rnt_rsp_if;
	import rnt_pkg::*;
	logic         valid;
	logic         ready;
	result_kind_t result_kind;
	node_t        out_target;
	msg_id_t      out_msg_id;
	status_t      out_status;

	modport source (
		output valid, result_kind, out_target, out_msg_id, out_status,
		input ready
	);
	modport sink (
		input valid, result_kind, out_target, out_msg_id, out_status,
		output ready
	);
endinterface

interface rnt_cfg_if;
	import rnt_pkg::*;
	logic       valid;
	logic       ready;
	reg_index_t reg_index;
	cfg_data_t  wdata;

	modport source (
		output valid, reg_index, wdata,
		input ready
	);
	modport sink (
		input valid, reg_index, wdata,
		output ready
	);
endinterface

>>> src/rnt_entry_store.sv
// entry payload memory: one write port, one registered read port
module rnt_entry_store #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter int DATA_W = 88
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/rejection_notice_table.sv
// rejection notice table top level
// One transaction on req is worked on at a time; req is ready only when the table is idle.
// An insert walks every entry up to the capacity once through the single read port of the
// entry memory, comparing one message id per cycle. A drain walks the pending flags from
// the cursor one entry per cycle, then reads the chosen entry from the memory. After the
// capacity has been lowered, the cursor is first brought below the capacity by repeated
// subtraction. A zero capacity or a rate-limited drain skips the walk and goes straight to
// the result. A finished result sits in an output register, so the next transaction is
// taken while it waits on rsp.
module rejection_notice_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_BITS     = 64
) (
	input logic      clk,
	input logic      arst_n,
	rnt_req_if.sink  req,
	rnt_rsp_if.source rsp,
	rnt_cfg_if.sink  cfg
);
	import rnt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CAP_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CAP_W > ENTRIES_W) ? CAP_W : ENTRIES_W;
	localparam int ROW_W = ID_BITS + NODE_W + STATUS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_ISCAN,
		ST_DSCAN,
		ST_DREAD,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [ENTRIES_W-1:0]   entries_q;
	logic [INTERVAL_W-1:0]  interval_q;
	logic [TABLE_DEPTH-1:0] used_q;
	logic [TABLE_DEPTH-1:0] pend_q;
	logic [IDX_W-1:0]       cursor_q;
	step_t                  last_q;

	op_t                    op_q;
	logic [ID_BITS-1:0]     id_q;
	node_t                  target_q;
	status_t                status_q;
	step_t                  now_q;
	logic                   link_q;

	logic [IDX_W-1:0]       rem_q;
	logic [CAP_W-1:0]       k_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   match_found_q;
	logic [IDX_W-1:0]       match_idx_q;

	logic                   scan_valid_s1;
	logic [IDX_W-1:0]       scan_idx_s1;
	logic                   scan_used_s1;

	result_kind_t           res_kind_q;
	node_t                  res_target_q;
	logic [ID_BITS-1:0]     res_id_q;
	status_t                res_status_q;

	logic                   rsp_valid_q;
	result_kind_t           rsp_kind_q;
	node_t                  rsp_target_q;
	logic [ID_BITS-1:0]     rsp_id_q;
	status_t                rsp_status_q;

	logic [CMP_W-1:0]       ent_ext;
	logic [CAP_W-1:0]       cap;
	step_t                  step_diff;
	logic                   rate_block;
	logic [ROW_W-1:0]       row_rd;
	logic [ID_BITS-1:0]     rd_id;
	node_t                  rd_target;
	status_t                rd_status;
	logic                   match_now;
	logic [IDX_W-1:0]       k_idx;
	logic [IDX_W-1:0]       idx_next;
	logic [IDX_W-1:0]       rem_next;
	logic [IDX_W-1:0]       ins_pick;
	logic                   hit;
	logic                   row_we;
	logic [IDX_W-1:0]       raddr;

	// capacity saturates at the table depth
	assign ent_ext    = CMP_W'(entries_q);
	assign cap        = CAP_W'((ent_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : ent_ext);
	assign step_diff  = req.step_now - last_q;
	assign rate_block = (last_q != '0) && (step_diff < STEP_W'(interval_q));

	assign rd_id     = row_rd[ROW_W-1 -: ID_BITS];
	assign rd_target = row_rd[NODE_W+STATUS_W-1 -: NODE_W];
	assign rd_status = row_rd[STATUS_W-1:0];

	assign match_now = scan_valid_s1 && scan_used_s1 && (rd_id == id_q);
	assign k_idx     = k_q[IDX_W-1:0];
	assign idx_next  = ((CAP_W'(idx_q) + CAP_W'(1)) == cap) ? '0 : idx_q + IDX_W'(1);
	assign rem_next  = ((CAP_W'(rem_q) + CAP_W'(1)) == cap) ? '0 : rem_q + IDX_W'(1);
	assign hit       = used_q[idx_q] && pend_q[idx_q];

	// same id first, then lowest free entry, then eviction at the cursor
	always_comb begin
		if (match_found_q) begin
			ins_pick = match_idx_q;
		end else if (match_now) begin
			ins_pick = scan_idx_s1;
		end else if (free_found_q) begin
			ins_pick = free_idx_q;
		end else begin
			ins_pick = rem_q;
		end
	end

	assign row_we = (state_q == ST_ISCAN) && (k_q == cap);
	assign raddr  = (state_q == ST_DSCAN) ? idx_q : k_idx;

	rnt_entry_store #(
		.DEPTH  (TABLE_DEPTH),
		.IDX_W  (IDX_W),
		.DATA_W (ROW_W)
	) u_store (
		.clk   (clk),
		.we    (row_we),
		.waddr (ins_pick),
		.wdata ({id_q, target_q, status_q}),
		.raddr (raddr),
		.rdata (row_rd)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= ENTRIES_W'(16);
			interval_q <= INTERVAL_W'(1);
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_ENTRIES_IN_USE:    entries_q  <= cfg.wdata[ENTRIES_W-1:0];
				REG_MIN_SEND_INTERVAL: interval_q <= cfg.wdata[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			pend_q        <= '0;
			cursor_q      <= '0;
			last_q        <= '0;
			op_q          <= OP_INSERT;
			id_q          <= '0;
			target_q      <= '0;
			status_q      <= '0;
			now_q         <= '0;
			link_q        <= 1'b0;
			rem_q         <= '0;
			k_q           <= '0;
			idx_q         <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			scan_valid_s1 <= 1'b0;
			scan_idx_s1   <= '0;
			scan_used_s1  <= 1'b0;
			res_kind_q    <= RES_INSERTED;
			res_target_q  <= '0;
			res_id_q      <= '0;
			res_status_q  <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_kind_q    <= RES_INSERTED;
			rsp_target_q  <= '0;
			rsp_id_q      <= '0;
			rsp_status_q  <= '0;
		end else begin
			scan_valid_s1 <= (state_q == ST_ISCAN) && (k_q != cap);
			if (rsp_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q          <= req.op;
						id_q          <= req.msg_id[ID_BITS-1:0];
						target_q      <= req.target_node;
						status_q      <= req.reject_status;
						now_q         <= req.step_now;
						link_q        <= req.link_accepts;
						res_target_q  <= '0;
						res_id_q      <= '0;
						res_status_q  <= '0;
						rem_q         <= cursor_q;
						k_q           <= '0;
						free_found_q  <= 1'b0;
						match_found_q <= 1'b0;
						if (cap == '0) begin
							res_kind_q <= (req.op == OP_DRAIN) ? RES_NOTHING : RES_DISABLED;
							state_q    <= ST_DONE;
						end else if ((req.op == OP_DRAIN) && rate_block) begin
							res_kind_q <= RES_NOTHING;
							state_q    <= ST_DONE;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					// cursor modulo capacity by repeated subtraction
					if (CAP_W'(rem_q) >= cap) begin
						rem_q <= IDX_W'(CAP_W'(rem_q) - cap);
					end else begin
						idx_q   <= rem_q;
						state_q <= (op_q == OP_DRAIN) ? ST_DSCAN : ST_ISCAN;
					end
				end
				ST_ISCAN: begin
					if (match_now && !match_found_q) begin
						match_found_q <= 1'b1;
						match_idx_q   <= scan_idx_s1;
					end
					if (k_q != cap) begin
						scan_idx_s1  <= k_idx;
						scan_used_s1 <= used_q[k_idx];
						if (!used_q[k_idx] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= k_idx;
						end
						k_q <= k_q + CAP_W'(1);
					end else begin
						used_q[ins_pick] <= 1'b1;
						pend_q[ins_pick] <= 1'b1;
						if (!match_found_q && !match_now && !free_found_q) begin
							cursor_q <= rem_next;
						end
						res_kind_q <= RES_INSERTED;
						state_q    <= ST_DONE;
					end
				end
				ST_DSCAN: begin
					if (hit) begin
						cursor_q <= idx_next;
						if (link_q) begin
							pend_q[idx_q] <= 1'b0;
							last_q        <= now_q;
							res_kind_q    <= RES_SENT;
						end else begin
							res_kind_q <= RES_REFUSED;
						end
						state_q <= ST_DREAD;
					end else if ((k_q + CAP_W'(1)) == cap) begin
						res_kind_q <= RES_NOTHING;
						state_q    <= ST_DONE;
					end else begin
						k_q   <= k_q + CAP_W'(1);
						idx_q <= idx_next;
					end
				end
				ST_DREAD: begin
					res_target_q <= rd_target;
					res_id_q     <= rd_id;
					res_status_q <= rd_status;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_kind_q   <= res_kind_q;
						rsp_target_q <= res_target_q;
						rsp_id_q     <= res_id_q;
						rsp_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.out_target  = rsp_target_q;
	assign rsp.out_msg_id  = ID_W'(rsp_id_q);
	assign rsp.out_status  = rsp_status_q;

`ifndef SYNTH
	a_pend_implies_used: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~used_q) == '0)
		else $error("pending entry that is not in use");

	a_scan_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISCAN) |-> (CAP_W'(rem_q) < cap))
		else $error("insert scan with cursor not reduced below capacity");

	a_drain_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSCAN) |-> ((k_q < cap) && (CAP_W'(idx_q) < cap)))
		else $error("drain walk beyond capacity");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside of completion");
`endif

endmodule

>>> tb/testbench.sv
// self-checking testbench of the rejection notice table
module testbench;
	import rnt_pkg::*;

	localparam int DEPTH = 16;
	localparam int HALF_PERIOD = 6;
	localparam int ID_POOL = 24;
	localparam int LIMIT_CYCLES = 800000;

	typedef struct packed {
		op_t     op;
		msg_id_t msg_id;
		node_t   node;
		status_t status;
		step_t   step;
		logic    accepts;
	} request_t;

	typedef struct packed {
		result_kind_t kind;
		node_t        node;
		msg_id_t      msg_id;
		status_t      status;
	} notice_t;

	logic clk;
	logic arst_n;

	rnt_req_if req_bus();
	rnt_rsp_if rsp_bus();
	rnt_cfg_if cfg_bus();

	rejection_notice_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	// mirror of the table contents
	logic                  slot_used[DEPTH];
	logic                  slot_pending[DEPTH];
	msg_id_t               slot_id[DEPTH];
	node_t                 slot_node[DEPTH];
	status_t               slot_status[DEPTH];
	int unsigned           cursor;
	step_t                 last_sent;
	logic [ENTRIES_W-1:0]  cap_reg;
	logic [INTERVAL_W-1:0] interval_reg;

	request_t requests_waiting[$];
	notice_t  notices_due[$];
	msg_id_t  id_pool[ID_POOL];
	step_t    step_clock;
	request_t next_req;
	request_t seen_req;
	notice_t  want;
	logic     req_taken;
	int       req_idle_pct;
	int       rsp_idle_pct;
	int       failures;

	function automatic notice_t predict_notice(request_t it);
		notice_t     r;
		int unsigned cap;
		int unsigned pick;
		int unsigned idx;
		int unsigned start;
		int unsigned i;
		bit          found;
		r = '0;
		cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		if (it.op == OP_INSERT) begin
			if (cap == 0) begin
				r.kind = RES_DISABLED;
				return r;
			end
			found = 1'b0;
			pick = 0;
			// a matching id wins over an earlier free slot
			for (i = 0; i < cap; i++) begin
				if (slot_used[i] && slot_id[i] == it.msg_id) begin
					pick = i;
					found = 1'b1;
					break;
				end
				if (!found && !slot_used[i]) begin
					pick = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				pick = cursor % cap;
				cursor = (pick + 1) % cap;
			end
			slot_used[pick] = 1'b1;
			slot_pending[pick] = 1'b1;
			slot_id[pick] = it.msg_id;
			slot_node[pick] = it.node;
			slot_status[pick] = it.status;
			r.kind = RES_INSERTED;
			return r;
		end
		r.kind = RES_NOTHING;
		if (last_sent != 0 && step_t'(it.step - last_sent) < interval_reg)
			return r;
		if (cap == 0)
			return r;
		start = cursor % cap;
		for (i = 0; i < cap; i++) begin
			idx = (start + i) % cap;
			if (slot_used[idx] && slot_pending[idx]) begin
				cursor = (idx + 1) % cap;
				r.node = slot_node[idx];
				r.msg_id = slot_id[idx];
				r.status = slot_status[idx];
				if (it.accepts) begin
					slot_pending[idx] = 1'b0;
					last_sent = it.step;
					r.kind = RES_SENT;
				end else begin
					r.kind = RES_REFUSED;
				end
				return r;
			end
		end
		return r;
	endfunction

	function automatic request_t request_of(op_t op, msg_id_t id, node_t node, status_t status,
			step_t step, logic accepts);
		request_t it;
		it.op = op;
		it.msg_id = id;
		it.node = node;
		it.status = status;
		it.step = step;
		it.accepts = accepts;
		return it;
	endfunction

	function automatic request_t random_request(int drain_pct, int jump);
		request_t it;
		int       pick;
		it.op = ($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_INSERT;
		if ($urandom_range(9) < 7)
			it.msg_id = id_pool[$urandom_range(ID_POOL - 1)];
		else
			it.msg_id = {$urandom, $urandom};
		it.node = node_t'($urandom);
		it.status = status_t'($urandom);
		pick = $urandom_range(39);
		if (pick == 0)
			step_clock = $urandom;
		else if (pick == 1)
			step_clock = '0;
		else
			step_clock += $urandom_range(jump);
		it.step = step_clock;
		it.accepts = ($urandom_range(9) != 0);
		return it;
	endfunction

	task automatic check_field(string name, logic [63:0] expected_v, logic [63:0] actual_v);
		if (expected_v !== actual_v) begin
			$error("%s: expected %0h, got %0h", name, expected_v, actual_v);
			failures++;
		end
	endtask

	task automatic write_reg(reg_index_t idx, cfg_data_t data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wdata <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		if (idx == REG_ENTRIES_IN_USE)
			cap_reg = data[ENTRIES_W-1:0];
		else
			interval_reg = data[INTERVAL_W-1:0];
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_config(cfg_data_t entries, cfg_data_t interval);
		write_reg(REG_ENTRIES_IN_USE, entries);
		write_reg(REG_MIN_SEND_INTERVAL, interval);
	endtask

	task automatic wait_drained();
		while (requests_waiting.size() != 0 || req_bus.valid || notices_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(int count, int drain_pct, int jump, int idle_pct);
		req_idle_pct = idle_pct;
		rsp_idle_pct = idle_pct;
		repeat (count) requests_waiting.push_back(random_request(drain_pct, jump));
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		#(2 * HALF_PERIOD * LIMIT_CYCLES);
		$display("testbench failed");
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n && (!req_bus.valid || req_taken)) begin
			if (requests_waiting.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
				next_req = requests_waiting.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.op <= next_req.op;
				req_bus.msg_id <= next_req.msg_id;
				req_bus.target_node <= next_req.node;
				req_bus.reject_status <= next_req.status;
				req_bus.step_now <= next_req.step;
				req_bus.link_accepts <= next_req.accepts;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
		rsp_bus.ready <= arst_n && ($urandom_range(99) >= rsp_idle_pct);
	end

	always @(posedge clk) begin
		req_taken <= req_bus.valid && req_bus.ready;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				seen_req = request_of(req_bus.op, req_bus.msg_id, req_bus.target_node,
					req_bus.reject_status, req_bus.step_now, req_bus.link_accepts);
				notices_due.push_back(predict_notice(seen_req));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (notices_due.size() == 0) begin
					$error("result transaction with no expected result waiting");
					failures++;
				end else begin
					want = notices_due.pop_front();
					check_field("result_kind", want.kind, rsp_bus.result_kind);
					check_field("out_target", want.node, rsp_bus.out_target);
					check_field("out_msg_id", want.msg_id, rsp_bus.out_msg_id);
					check_field("out_status", want.status, rsp_bus.out_status);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.op = OP_INSERT;
		req_bus.msg_id = '0;
		req_bus.target_node = '0;
		req_bus.reject_status = '0;
		req_bus.step_now = '0;
		req_bus.link_accepts = 1'b0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = REG_ENTRIES_IN_USE;
		cfg_bus.wdata = '0;
		req_taken = 1'b0;
		failures = 0;
		step_clock = '0;
		req_idle_pct = 36;
		rsp_idle_pct = 36;
		foreach (slot_used[i]) begin
			slot_used[i] = 1'b0;
			slot_pending[i] = 1'b0;
			slot_id[i] = '0;
			slot_node[i] = '0;
			slot_status[i] = '0;
		end
		cursor = 0;
		last_sent = '0;
		cap_reg = 5'd16;
		interval_reg = 16'd1;
		foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
		id_pool[0] = '1;
		id_pool[1] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: reuse, send at step zero, refusal, rate limit, step wrap
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, '1, '1, '1, 32'd7, 1'b0));
		requests_waiting.push_back(request_of(OP_INSERT, '0, '0, '0, '1, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, '1, 16'h1234, 8'h5a, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '1, '1, '1, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, '0, 1'b0));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd100, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 16'haaaa,
			8'haa, 32'd100, 1'b0));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd100, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, '1, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, 64'h5555_5555_5555_5555, 16'h5555,
			8'h55, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, '0, 1'b1));
		wait_drained();

		// two entries: eviction at the cursor
		set_config(16'd2, 16'd0);
		requests_waiting.push_back(request_of(OP_INSERT, 64'h1, 16'h0001, 8'h01, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, 64'h2, 16'h0002, 8'h02, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_INSERT, 64'h1, 16'h0011, 8'h11, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd5, 1'b0));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd5, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd5, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd6, 1'b1));
		wait_drained();

		// table disabled
		set_config(16'd0, 16'd0);
		requests_waiting.push_back(request_of(OP_INSERT, 64'h3, 16'h0003, 8'h03, '0, 1'b1));
		requests_waiting.push_back(request_of(OP_DRAIN, '0, '0, '0, 32'd9, 1'b1));
		wait_drained();

		// upper data bits of the capacity write are dropped
		set_config(16'hffe3, 16'd5);
		run_random(250, 45, 8, 36);
		set_config(16'd31, 16'd0);
		run_random(400, 45, 3, 0);
		set_config(16'd16, 16'hffff);
		run_random(250, 50, 40000, 36);
		set_config(16'd1, 16'd1);
		run_random(200, 45, 3, 36);
		set_config(16'd0, 16'd3);
		run_random(60, 50, 3, 36);
		set_config(16'd8, 16'd300);
		run_random(300, 45, 200, 36);
		set_config(16'd16, 16'd2);
		run_random(500, 45, 4, 36);

		wait_drained();
		repeat (40) @(posedge clk);
		if (failures == 0 && notices_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

>>> filelist.f
src/rnt_pkg.sv
src/rnt_if.sv
src/rnt_entry_store.sv
src/rejection_notice_table.sv
tb/testbench.sv
